// ===== sv/lift_reset_torque_sequencer_assert.svh =====
// Assertion macros for the lift reset torque sequencer.
// Each macro is used on a line of its own, without a trailing semicolon.
`ifndef LIFT_RESET_TORQUE_SEQUENCER_ASSERT_SVH
`define LIFT_RESET_TORQUE_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS

`define LRTS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define LRTS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define LRTS_ASSERT_IMP(label, clk, rst, ante, cons, msg)

`define LRTS_ASSERT_NXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== sv/lrts_pkg.sv =====
`default_nettype none

package lrts_pkg;

  typedef enum logic [2:0] {
    MODE_TICK   = 3'd0,
    MODE_UP     = 3'd1,
    MODE_DOWN   = 3'd2,
    MODE_REMOVE = 3'd3,
    MODE_ADD    = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    PH_UNINIT = 3'd0,
    PH_IDLE   = 3'd1,
    PH_UP     = 3'd2,
    PH_DOWN   = 3'd3,
    PH_ADD    = 3'd4,
    PH_REMOVE = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    REG_TORQUE_LIMIT  = 2'd0,
    REG_SLACK_TIMEOUT = 2'd1,
    REG_SLACK_GAIN    = 2'd2
  } reg_index_t;

  localparam int HEIGHT_W   = 20;
  localparam int POS_W      = 32;
  localparam int TORQUE_W   = 11;
  localparam int SLACK_W    = 28;
  localparam int LIMIT_W    = 14;
  localparam int TIMEOUT_W  = 16;
  localparam int GAIN_W     = 24;

  localparam logic signed [TORQUE_W-1:0] TQ_ZERO     = 11'sd0;
  localparam logic signed [TORQUE_W-1:0] TQ_FIRST    = 11'sd800;
  localparam logic signed [TORQUE_W-1:0] TQ_SECOND   = 11'sd600;
  localparam logic signed [TORQUE_W-1:0] TQ_THIRD    = 11'sd400;
  localparam logic signed [TORQUE_W-1:0] TQ_HOLD     = 11'sd300;
  localparam logic signed [TORQUE_W-1:0] TQ_PAY_OUT  = -11'sd300;

  localparam logic [HEIGHT_W-1:0] MOVE_THRESHOLD = 20'd1000;

  localparam logic [LIMIT_W-1:0]   LIMIT_RESET   = 14'd1000;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd5000;
  localparam logic [GAIN_W-1:0]    GAIN_RESET    = 24'd410127;

  // One decoded request as it sits in the input register.
  typedef struct packed {
    mode_t                     mode;
    logic [HEIGHT_W-1:0]       target;
    logic [HEIGHT_W-1:0]       height;
    logic signed [POS_W-1:0]   motor_position;
    logic [HEIGHT_W-1:0]       band_one;
    logic [HEIGHT_W-1:0]       band_two;
    logic [SLACK_W-1:0]        slack_distance;
  } item_t;

  typedef struct packed {
    logic [LIMIT_W-1:0]   torque_limit;
    logic [TIMEOUT_W-1:0] slack_timeout;
  } cfg_t;

endpackage

`default_nettype wire

// ===== sv/lrts_front.sv =====
`default_nettype none

// Input register. The band edges of a go-up command and the slack distance of
// an add-slack command are worked out here, so the core only compares.
module lrts_front (
  input  wire logic                            clk,
  input  wire logic                            load,
  input  wire lrts_pkg::mode_t                 mode,
  input  wire logic [lrts_pkg::HEIGHT_W-1:0]   target,
  input  wire logic [lrts_pkg::HEIGHT_W-1:0]   height,
  input  wire logic signed [lrts_pkg::POS_W-1:0] motor_position,
  input  wire logic [lrts_pkg::GAIN_W-1:0]     slack_gain,
  output lrts_pkg::item_t                      item
);

  // floor(a/3) = (a * RECIP) >> SHIFT, exact for a below 2**(SHIFT-1).
  localparam int DIV3_SHIFT = 22;
  localparam logic [20:0] DIV3_RECIP = 21'((2**DIV3_SHIFT + 2) / 3);

  logic signed [20:0] climb;
  logic               climb_neg;
  logic [19:0]        climb_abs;
  logic [40:0]        div_prod;
  logic [18:0]        third;
  logic [19:0]        rem_full;
  logic [19:0]        two_thirds;
  logic [19:0]        band_one_next;
  logic [19:0]        band_two_next;
  logic [43:0]        slack_prod;
  lrts_pkg::item_t    item_next;

  always_comb begin
    climb     = $signed({1'b0, height}) - $signed({1'b0, target});
    climb_neg = climb[20];
    climb_abs = climb_neg ? 20'(-climb) : climb[19:0];
    div_prod  = 41'(climb_abs) * 41'(DIV3_RECIP);
    third     = div_prod[40:DIV3_SHIFT];
    rem_full  = climb_abs - {third, 1'b0} - {1'b0, third};
    // floor(2a/3) is twice floor(a/3), plus one when the remainder is two.
    two_thirds = {third, 1'b0} + {19'd0, (rem_full[1:0] == 2'd2)};
    // Truncation toward zero: the band edges move by the magnitude, signed.
    band_one_next = climb_neg ? height + {1'b0, third} : height - {1'b0, third};
    band_two_next = climb_neg ? height + two_thirds : height - two_thirds;
    slack_prod = 44'(target) * 44'(slack_gain);

    item_next.mode           = mode;
    item_next.target         = target;
    item_next.height         = height;
    item_next.motor_position = motor_position;
    item_next.band_one       = band_one_next;
    item_next.band_two       = band_two_next;
    item_next.slack_distance = slack_prod[43:16];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= item_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/lrts_core.sv =====
`default_nettype none

// Sequencer state and result register. One request is retired per fire.
module lrts_core (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               fire,
  input  wire lrts_pkg::item_t                    item,
  input  wire lrts_pkg::cfg_t                     cfg,
  output logic signed [lrts_pkg::TORQUE_W-1:0]    torque,
  output lrts_pkg::phase_t                        phase
);

  lrts_pkg::phase_t                          lift_phase, lift_phase_next;
  logic [lrts_pkg::HEIGHT_W-1:0]             band_start, band_start_next;
  logic [lrts_pkg::HEIGHT_W-1:0]             band_one, band_one_next;
  logic [lrts_pkg::HEIGHT_W-1:0]             band_two, band_two_next;
  logic [lrts_pkg::HEIGHT_W-1:0]             goal_height, goal_height_next;
  logic [lrts_pkg::HEIGHT_W-1:0]             captured_height, captured_height_next;
  logic [lrts_pkg::TIMEOUT_W-1:0]            drive_ticks, drive_ticks_next;
  logic signed [lrts_pkg::POS_W-1:0]         start_position, start_position_next;
  logic [lrts_pkg::SLACK_W-1:0]              slack_distance, slack_distance_next;
  logic signed [lrts_pkg::TORQUE_W-1:0]      torque_next;

  logic signed [lrts_pkg::TORQUE_W-1:0]      up_torque;
  logic                                      up_done;
  logic signed [20:0]                        height_delta;
  logic [19:0]                               height_moved;
  logic signed [lrts_pkg::POS_W:0]           pos_moved;

  // Go-up torque: later bands override earlier ones, as the climb proceeds.
  always_comb begin
    up_torque = lrts_pkg::TQ_ZERO;
    up_done   = 1'b0;
    if (item.height > band_start) begin
      up_torque = lrts_pkg::TQ_FIRST;
    end
    if (band_start >= item.height && item.height > band_one) begin
      up_torque = lrts_pkg::TQ_FIRST;
    end
    if (band_one >= item.height && item.height > band_two) begin
      up_torque = lrts_pkg::TQ_SECOND;
    end
    if (band_two >= item.height && item.height > goal_height) begin
      up_torque = lrts_pkg::TQ_THIRD;
    end
    if (goal_height >= item.height) begin
      up_torque = lrts_pkg::TQ_HOLD;
      up_done   = 1'b1;
    end
    if ($signed({4'd0, up_torque}) > $signed({1'b0, cfg.torque_limit})) begin
      up_torque = lrts_pkg::TQ_ZERO;
    end
  end

  always_comb begin
    height_delta = $signed({1'b0, item.height}) - $signed({1'b0, captured_height});
    height_moved = height_delta[20] ? 20'(-height_delta) : height_delta[19:0];
    pos_moved    = (lrts_pkg::POS_W+1)'(start_position) -
                   (lrts_pkg::POS_W+1)'(item.motor_position);
  end

  always_comb begin
    lift_phase_next      = lift_phase;
    band_start_next      = band_start;
    band_one_next        = band_one;
    band_two_next        = band_two;
    goal_height_next     = goal_height;
    captured_height_next = captured_height;
    drive_ticks_next     = drive_ticks;
    start_position_next  = start_position;
    slack_distance_next  = slack_distance;
    torque_next          = lrts_pkg::TQ_ZERO;

    case (item.mode)
      lrts_pkg::MODE_UP: begin
        band_start_next      = item.height;
        captured_height_next = item.height;
        goal_height_next     = item.target;
        band_one_next        = item.band_one;
        band_two_next        = item.band_two;
        lift_phase_next      = lrts_pkg::PH_UP;
      end
      lrts_pkg::MODE_DOWN: begin
        goal_height_next     = item.target;
        captured_height_next = item.height;
        lift_phase_next      = lrts_pkg::PH_DOWN;
      end
      lrts_pkg::MODE_REMOVE: begin
        captured_height_next = item.height;
        drive_ticks_next     = '0;
        lift_phase_next      = lrts_pkg::PH_REMOVE;
      end
      lrts_pkg::MODE_ADD: begin
        start_position_next = item.motor_position;
        slack_distance_next = item.slack_distance;
        lift_phase_next     = lrts_pkg::PH_ADD;
      end
      default: begin
        // A plain tick, and the unused mode codes, run the armed motion.
        case (lift_phase)
          lrts_pkg::PH_UP: begin
            torque_next = up_torque;
            if (up_done) begin
              lift_phase_next = lrts_pkg::PH_IDLE;
            end
          end
          lrts_pkg::PH_DOWN: begin
            if (item.height >= goal_height) begin
              torque_next     = lrts_pkg::TQ_HOLD;
              lift_phase_next = lrts_pkg::PH_IDLE;
            end
          end
          lrts_pkg::PH_REMOVE: begin
            if (drive_ticks < cfg.slack_timeout &&
                height_moved < lrts_pkg::MOVE_THRESHOLD) begin
              torque_next      = lrts_pkg::TQ_HOLD;
              drive_ticks_next = drive_ticks + 1'b1;
            end else begin
              lift_phase_next = lrts_pkg::PH_IDLE;
            end
          end
          lrts_pkg::PH_ADD: begin
            if (pos_moved < $signed({5'd0, slack_distance})) begin
              torque_next = lrts_pkg::TQ_PAY_OUT;
            end else begin
              lift_phase_next = lrts_pkg::PH_IDLE;
            end
          end
          default: begin
            torque_next = lrts_pkg::TQ_ZERO;
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lift_phase      <= lrts_pkg::PH_UNINIT;
      band_start      <= '0;
      band_one        <= '0;
      band_two        <= '0;
      goal_height     <= '0;
      captured_height <= '0;
      drive_ticks     <= '0;
      start_position  <= '0;
      slack_distance  <= '0;
    end else if (fire) begin
      lift_phase      <= lift_phase_next;
      band_start      <= band_start_next;
      band_one        <= band_one_next;
      band_two        <= band_two_next;
      goal_height     <= goal_height_next;
      captured_height <= captured_height_next;
      drive_ticks     <= drive_ticks_next;
      start_position  <= start_position_next;
      slack_distance  <= slack_distance_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      torque <= torque_next;
      phase  <= lift_phase_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/lift_reset_torque_sequencer.sv =====
// Channel   | Direction | Payload
// s_axis    | in        | tuser: mode; tdata: target, height, motor_position
// m_axis    | out       | tdata: torque, phase
// cfg       | in        | cfg_index selects the register, cfg_data is the value
//
// A request is accepted every cycle while s_axis_tready is high; its result appears
// after the input register and the result register.
// Reset clears the sequencer to uninitialized and loads the register defaults.
// While a result waits on m_axis, one more request is still taken into the
// input register; after that s_axis_tready drops until the result leaves.
`default_nettype none

`include "lift_reset_torque_sequencer_assert.svh"

module lift_reset_torque_sequencer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,  // target[19:0], height[39:20], motor_position[71:40]
  input  wire logic [2:0]  s_axis_tuser,  // mode[2:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // torque[10:0], phase[13:11], zero[15:14]
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);

  logic                                   in_valid;
  logic                                   out_valid;
  logic                                   advance;
  logic                                   fire;
  logic                                   accept;
  logic [lrts_pkg::LIMIT_W-1:0]           torque_limit;
  logic [lrts_pkg::TIMEOUT_W-1:0]         slack_timeout;
  logic [lrts_pkg::GAIN_W-1:0]            slack_gain;
  lrts_pkg::cfg_t                         cfg;
  lrts_pkg::item_t                        item;
  logic signed [lrts_pkg::TORQUE_W-1:0]   torque;
  lrts_pkg::phase_t                       phase;
  logic                                   cmd_fire;
  logic                                   cmd_result_ok;
  logic                                   neg_result;
  logic                                   in_add;

  assign advance       = !out_valid || m_axis_tready;
  assign fire          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, phase, torque};

  assign cfg.torque_limit  = torque_limit;
  assign cfg.slack_timeout = slack_timeout;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        in_valid <= 1'b1;
      end else if (fire) begin
        in_valid <= 1'b0;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      torque_limit  <= lrts_pkg::LIMIT_RESET;
      slack_timeout <= lrts_pkg::TIMEOUT_RESET;
      slack_gain    <= lrts_pkg::GAIN_RESET;
    end else if (cfg_we) begin
      case (lrts_pkg::reg_index_t'(cfg_index))
        lrts_pkg::REG_TORQUE_LIMIT:  torque_limit  <= cfg_data[lrts_pkg::LIMIT_W-1:0];
        lrts_pkg::REG_SLACK_TIMEOUT: slack_timeout <= cfg_data[lrts_pkg::TIMEOUT_W-1:0];
        lrts_pkg::REG_SLACK_GAIN:    slack_gain    <= cfg_data[lrts_pkg::GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lrts_front u_front (
    .clk            (clk),
    .load           (accept),
    .mode           (lrts_pkg::mode_t'(s_axis_tuser)),
    .target         (s_axis_tdata[19:0]),
    .height         (s_axis_tdata[39:20]),
    .motor_position (s_axis_tdata[71:40]),
    .slack_gain     (slack_gain),
    .item           (item)
  );

  lrts_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (item),
    .cfg    (cfg),
    .torque (torque),
    .phase  (phase)
  );

  assign cmd_fire      = fire && (item.mode inside {lrts_pkg::MODE_UP, lrts_pkg::MODE_DOWN,
                                                    lrts_pkg::MODE_REMOVE, lrts_pkg::MODE_ADD});
  assign cmd_result_ok = (torque == lrts_pkg::TQ_ZERO) && (phase != lrts_pkg::PH_UNINIT);
  assign neg_result    = m_axis_tvalid && torque[lrts_pkg::TORQUE_W-1];
  assign in_add        = (phase == lrts_pkg::PH_ADD);

  `LRTS_ASSERT_NXT(a_fire_gives_result, clk, rst, fire, m_axis_tvalid, "retired request lost")
  `LRTS_ASSERT_NXT(a_command_zero_torque, clk, rst, cmd_fire, cmd_result_ok, "command not zero")
  `LRTS_ASSERT_IMP(a_neg_only_add, clk, rst, neg_result, in_add, "negative torque outside add")

endmodule

`default_nettype wire

// ===== bench/lift_reset_torque_sequencer_tb.sv =====
module lift_reset_torque_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HMAX = (1 << lrts_pkg::HEIGHT_W) - 1;
  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_MID = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int N_SETTINGS = 6;
  localparam int ITEMS_PER_SETTING = 310;
  localparam int PRESSURE_CYCLES = 300;
  localparam int MAX_REPORTS = 10;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic signed [lrts_pkg::TORQUE_W-1:0] torque;
    lrts_pkg::phase_t                     phase;
  } drive_t;

  localparam drive_t NO_PIN = '{lrts_pkg::TQ_ZERO, lrts_pkg::PH_UNINIT};

  typedef struct {
    logic [2:0]                    mode;
    logic [lrts_pkg::HEIGHT_W-1:0] target;
    logic [lrts_pkg::HEIGHT_W-1:0] height;
    logic [lrts_pkg::POS_W-1:0]    pos;
    bit                            pinned;
    drive_t                        want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;   // target[19:0], height[39:20], motor_position[71:40]
  logic [2:0]  s_axis_tuser;   // mode[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // torque[10:0], phase[13:11], zero[15:14]
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_data;

  lift_reset_torque_sequencer i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sequencer state as the testbench tracks it.
  lrts_pkg::phase_t                   cur_phase;
  logic [lrts_pkg::HEIGHT_W-1:0]      up_from, up_third1, up_third2, goal_h, ref_h;
  logic [lrts_pkg::TIMEOUT_W-1:0]     drive_cnt;
  logic signed [lrts_pkg::POS_W-1:0]  pay_origin;
  logic [31:0]                        pay_len;
  logic [lrts_pkg::LIMIT_W-1:0]       lim_torque;
  logic [lrts_pkg::TIMEOUT_W-1:0]     lim_ticks;
  logic [lrts_pkg::GAIN_W-1:0]        gain_q16;

  drive_t torque_due [$];
  bit     pin_on;
  drive_t pin_want;
  bit     src_idle;
  bit     snk_idle;
  bit     pressure_go;
  int     sent;
  int     n_req;
  int     n_res;
  int     bad;
  int     cycles;
  int     cnt_mode [8];
  row_t   script [$];

  function automatic drive_t next_torque(logic [2:0] mode,
                                         logic [lrts_pkg::HEIGHT_W-1:0] target,
                                         logic [lrts_pkg::HEIGHT_W-1:0] height,
                                         logic signed [lrts_pkg::POS_W-1:0] pos);
    drive_t d;
    int h;
    int climb;
    int dh;
    int t;
    longint moved;
    logic [43:0] prod;
    h = int'(height);
    t = 0;
    case (mode)
      lrts_pkg::MODE_UP: begin
        climb = h - int'(target);
        up_from = height;
        ref_h = height;
        goal_h = target;
        up_third1 = 20'(h - climb / 3);
        up_third2 = 20'(h - (2 * climb) / 3);
        cur_phase = lrts_pkg::PH_UP;
      end
      lrts_pkg::MODE_DOWN: begin
        goal_h = target;
        ref_h = height;
        cur_phase = lrts_pkg::PH_DOWN;
      end
      lrts_pkg::MODE_REMOVE: begin
        ref_h = height;
        drive_cnt = '0;
        cur_phase = lrts_pkg::PH_REMOVE;
      end
      lrts_pkg::MODE_ADD: begin
        prod = target * gain_q16;
        pay_origin = pos;
        pay_len = 32'(prod >> 16);
        cur_phase = lrts_pkg::PH_ADD;
      end
      default: begin
        case (cur_phase)
          lrts_pkg::PH_UP: begin
            // Later bands override earlier ones, so the order matters.
            if (h > int'(up_from)) t = lrts_pkg::TQ_FIRST;
            if (int'(up_from) >= h && h > int'(up_third1)) t = lrts_pkg::TQ_FIRST;
            if (int'(up_third1) >= h && h > int'(up_third2)) t = lrts_pkg::TQ_SECOND;
            if (int'(up_third2) >= h && h > int'(goal_h)) t = lrts_pkg::TQ_THIRD;
            if (int'(goal_h) >= h) begin
              t = lrts_pkg::TQ_HOLD;
              cur_phase = lrts_pkg::PH_IDLE;
            end
            if (t > int'(lim_torque)) t = 0;
          end
          lrts_pkg::PH_DOWN: begin
            if (height >= goal_h) begin
              t = lrts_pkg::TQ_HOLD;
              cur_phase = lrts_pkg::PH_IDLE;
            end
          end
          lrts_pkg::PH_REMOVE: begin
            dh = h - int'(ref_h);
            if (dh < 0) dh = -dh;
            if (drive_cnt < lim_ticks && dh < int'(lrts_pkg::MOVE_THRESHOLD)) begin
              t = lrts_pkg::TQ_HOLD;
              drive_cnt = drive_cnt + 16'd1;
            end else begin
              cur_phase = lrts_pkg::PH_IDLE;
            end
          end
          lrts_pkg::PH_ADD: begin
            moved = longint'(pay_origin) - longint'(pos);
            if (moved < longint'(pay_len)) t = lrts_pkg::TQ_PAY_OUT;
            else cur_phase = lrts_pkg::PH_IDLE;
          end
          default: t = 0;
        endcase
      end
    endcase
    d.torque = 11'(t);
    d.phase = cur_phase;
    return d;
  endfunction

  always @(posedge clk) begin : check
    drive_t got;
    drive_t want;
    if (rst) begin
      cur_phase = lrts_pkg::PH_UNINIT;
      up_from = '0;
      up_third1 = '0;
      up_third2 = '0;
      goal_h = '0;
      ref_h = '0;
      drive_cnt = '0;
      pay_origin = '0;
      pay_len = '0;
      lim_torque = lrts_pkg::LIMIT_RESET;
      lim_ticks = lrts_pkg::TIMEOUT_RESET;
      gain_q16 = lrts_pkg::GAIN_RESET;
      torque_due.delete();
      foreach (cnt_mode[i]) cnt_mode[i] = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.torque = m_axis_tdata[10:0];
        got.phase = lrts_pkg::phase_t'(m_axis_tdata[13:11]);
        n_res++;
        if (torque_due.size() == 0) begin
          bad++;
          if (bad <= MAX_REPORTS)
            $display("%0t: result with none pending: torque %0d phase %0d",
                     $realtime, got.torque, got.phase);
        end else begin
          want = torque_due.pop_front();
          if (got.torque !== want.torque || got.phase !== want.phase) begin
            bad++;
            if (bad <= MAX_REPORTS)
              $display("%0t: result %0d: torque expected %0d got %0d, phase expected %0d got %0d",
                       $realtime, n_res, want.torque, got.torque, want.phase, got.phase);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          lrts_pkg::REG_TORQUE_LIMIT:  lim_torque = cfg_data[lrts_pkg::LIMIT_W-1:0];
          lrts_pkg::REG_SLACK_TIMEOUT: lim_ticks = cfg_data[lrts_pkg::TIMEOUT_W-1:0];
          lrts_pkg::REG_SLACK_GAIN:    gain_q16 = cfg_data[lrts_pkg::GAIN_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = next_torque(s_axis_tuser, s_axis_tdata[19:0], s_axis_tdata[39:20],
                           s_axis_tdata[71:40]);
        if (pin_on) want = pin_want;
        torque_due.push_back(want);
        n_req++;
        cnt_mode[s_axis_tuser]++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycles, torque_due.size());
      $display("lift_reset_torque_sequencer_tb: FAIL");
      $finish;
    end
  end

  // Result side: random hold-offs plus one long one so the block backs up.
  initial begin : sink
    int hold;
    bit pressed;
    hold = 0;
    pressed = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (pressure_go && !pressed) begin
        pressed = 1'b1;
        hold = PRESSURE_CYCLES;
      end else if (hold == 0 && snk_idle && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 15);
      end
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        hold--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic row_t mk_row(logic [2:0] mode, int target, int height,
                                  logic [31:0] pos, bit pinned, drive_t want);
    row_t r;
    r.mode = mode;
    r.target = 20'(target);
    r.height = 20'(height);
    r.pos = pos;
    r.pinned = pinned;
    r.want = want;
    return r;
  endfunction

  function automatic logic [lrts_pkg::HEIGHT_W-1:0] clamp_h(int v);
    if (v < 0) return '0;
    if (v > HMAX) return '1;
    return v[lrts_pkg::HEIGHT_W-1:0];
  endfunction

  function automatic logic [2:0] tick_mode();
    if ($urandom_range(0, 9) == 0) return 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
    return lrts_pkg::MODE_TICK;
  endfunction

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_req(logic [2:0] mode, logic [lrts_pkg::HEIGHT_W-1:0] target,
                          logic [lrts_pkg::HEIGHT_W-1:0] height, logic [31:0] pos,
                          bit pinned, drive_t want);
    if (src_idle && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    pin_on = pinned;
    pin_want = want;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mode;
    s_axis_tdata <= {pos, height, target};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic program_regs(logic [23:0] limit, logic [23:0] timeout, logic [23:0] gain);
    cfg_we <= 1'b1;
    cfg_index <= lrts_pkg::REG_TORQUE_LIMIT;
    cfg_data <= limit;
    @(negedge clk);
    cfg_index <= lrts_pkg::REG_SLACK_TIMEOUT;
    cfg_data <= timeout;
    @(negedge clk);
    cfg_index <= lrts_pkg::REG_SLACK_GAIN;
    cfg_data <= gain;
    @(negedge clk);
    // The spare index must leave every register alone.
    cfg_index <= REG_UNUSED;
    cfg_data <= '1;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (torque_due.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // One motion: a command followed by ticks that walk toward its end condition,
  // or else noise and broken sequences.
  task automatic run_motion();
    int kind;
    int n;
    int k;
    int h0;
    int tg;
    int base;
    int dv;
    longint span;
    longint p;
    logic [31:0] p0;
    kind = $urandom_range(0, 9);
    n = $urandom_range(1, 12);
    case (kind)
      0: begin
        repeat ($urandom_range(1, 4))
          send_req(3'($urandom_range(0, 7)), 20'($urandom), 20'($urandom), $urandom,
                   1'b0, NO_PIN);
      end
      1, 2: begin
        h0 = $urandom_range(0, HMAX);
        tg = ($urandom_range(0, 4) != 0) ? $urandom_range(0, h0) : $urandom_range(0, HMAX);
        send_req(lrts_pkg::MODE_UP, 20'(tg), 20'(h0), $urandom, 1'b0, NO_PIN);
        for (k = 0; k <= n + 1; k++) begin
          if (k == 0 && $urandom_range(0, 1) == 1) dv = $urandom_range(1, 5000);
          else dv = int'($urandom_range(0, 4000)) - 2000;
          send_req(tick_mode(), 20'($urandom), clamp_h(h0 - (h0 - tg) * k / n + dv),
                   $urandom, 1'b0, NO_PIN);
        end
      end
      3, 4: begin
        tg = $urandom_range(0, HMAX);
        base = $urandom_range(0, tg);
        send_req(lrts_pkg::MODE_DOWN, 20'(tg), 20'($urandom), $urandom, 1'b0, NO_PIN);
        for (k = 0; k <= n + 1; k++)
          send_req(tick_mode(), 20'($urandom),
                   clamp_h(base + (tg - base) * k / n + int'($urandom_range(0, 4)) - 2),
                   $urandom, 1'b0, NO_PIN);
      end
      5, 6: begin
        h0 = $urandom_range(0, HMAX);
        send_req(lrts_pkg::MODE_REMOVE, 20'($urandom), 20'(h0), $urandom, 1'b0, NO_PIN);
        for (k = 0; k <= 2 * n; k++) begin
          dv = int'($urandom_range(0, 2200)) - 1100;
          send_req(tick_mode(), 20'($urandom), clamp_h(h0 + dv), $urandom, 1'b0, NO_PIN);
        end
      end
      7, 8: begin
        tg = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 3000) : $urandom_range(0, HMAX);
        p0 = $urandom;
        span = (longint'(tg) * longint'(gain_q16)) >>> 16;
        send_req(lrts_pkg::MODE_ADD, 20'(tg), 20'($urandom), p0, 1'b0, NO_PIN);
        for (k = 0; k <= n + 1; k++) begin
          p = longint'($signed(p0)) - span * k / n + int'($urandom_range(0, 4)) - 2;
          send_req(tick_mode(), 20'($urandom), 20'($urandom), p[31:0], 1'b0, NO_PIN);
        end
      end
      default: begin
        send_req(3'($urandom_range(lrts_pkg::MODE_UP, lrts_pkg::MODE_ADD)), 20'($urandom),
                 20'($urandom), $urandom, 1'b0, NO_PIN);
        repeat ($urandom_range(0, 2))
          send_req(3'($urandom_range(0, 7)), 20'($urandom), 20'($urandom), $urandom,
                   1'b0, NO_PIN);
      end
    endcase
  endtask

  initial begin : main
    int ph;
    int goal;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = lrts_pkg::MODE_TICK;
    cfg_we = 1'b0;
    cfg_index = lrts_pkg::REG_TORQUE_LIMIT;
    cfg_data = '0;
    pin_on = 1'b0;
    pin_want = NO_PIN;
    src_idle = 1'b1;
    snk_idle = 1'b1;
    pressure_go = 1'b0;
    sent = 0;
    n_req = 0;
    n_res = 0;
    bad = 0;
    cycles = 0;

    // Default registers: limit 1000, timeout 5000, one micrometre of slack is
    // 410127/65536 position units.
    script.push_back(mk_row(lrts_pkg::MODE_TICK, HMAX, 0, 32'h8000_0000, 1'b1,
                            '{lrts_pkg::TQ_ZERO, lrts_pkg::PH_UNINIT}));
    script.push_back(mk_row(MODE_SPARE_HI, 0, HMAX, 32'h7FFF_FFFF, 1'b1,
                            '{lrts_pkg::TQ_ZERO, lrts_pkg::PH_UNINIT}));
    script.push_back(mk_row(lrts_pkg::MODE_UP, 0, 900000, 0, 1'b1,
                            '{lrts_pkg::TQ_ZERO, lrts_pkg::PH_UP}));
    script.push_back(mk_row(lrts_pkg::MODE_TICK, 0, HMAX, 0, 1'b1,
                            '{lrts_pkg::TQ_FIRST, lrts_pkg::PH_UP}));
    script.push_back(mk_row(lrts_pkg::MODE_TICK, 0, 700000, 0, 1'b1,
                            '{lrts_pkg::TQ_FIRST, lrts_pkg::PH_UP}));
    script.push_back(mk_row(lrts_pkg::MODE_TICK, 0, 500000, 0, 1'b1,
                            '{lrts_pkg::TQ_SECOND, lrts_pkg::PH_UP}));
    script.push_back(mk_row(lrts_pkg::MODE_TICK, 0, 100000, 0, 1'b1,
                            '{lrts_pkg::TQ_THIRD, lrts_pkg::PH_UP}));
    script.push_back(mk_row(lrts_pkg::MODE_TICK, 0, 0, 0, 1'b1,
                            '{lrts_pkg::TQ_HOLD, lrts_pkg::PH_IDLE}));
    script.push_back(mk_row(MODE_SPARE_LO, HMAX, HMAX, 0, 1'b1,
                            '{lrts_pkg::TQ_ZERO, lrts_pkg::PH_IDLE}));
    script.push_back(mk_row(lrts_pkg::MODE_DOWN, 500000, 0, 0, 1'b1,
                            '{lrts_pkg::TQ_ZERO, lrts_pkg::PH_DOWN}));
    script.push_back(mk_row(lrts_pkg::MODE_TICK, 0, 499999, 0, 1'b1,
                            '{lrts_pkg::TQ_ZERO, lrts_pkg::PH_DOWN}));
    script.push_back(mk_row(lrts_pkg::MODE_TICK, 0, 500000, 0, 1'b1,
                            '{lrts_pkg::TQ_HOLD, lrts_pkg::PH_IDLE}));
    script.push_back(mk_row(lrts_pkg::MODE_REMOVE, 0, 1000, 0, 1'b1,
                            '{lrts_pkg::TQ_ZERO, lrts_pkg::PH_REMOVE}));
    script.push_back(mk_row(lrts_pkg::MODE_TICK, 0, 1999, 0, 1'b1,
                            '{lrts_pkg::TQ_HOLD, lrts_pkg::PH_REMOVE}));
    script.push_back(mk_row(lrts_pkg::MODE_TICK, 0, 1, 0, 1'b1,
                            '{lrts_pkg::TQ_HOLD, lrts_pkg::PH_REMOVE}));
    script.push_back(mk_row(lrts_pkg::MODE_TICK, 0, 0, 0, 1'b1,
                            '{lrts_pkg::TQ_ZERO, lrts_pkg::PH_IDLE}));
    script.push_back(mk_row(lrts_pkg::MODE_ADD, 1000, 0, 0, 1'b1,
                            '{lrts_pkg::TQ_ZERO, lrts_pkg::PH_ADD}));
    script.push_back(mk_row(lrts_pkg::MODE_TICK, 0, 0, -32'sd6257, 1'b1,
                            '{lrts_pkg::TQ_PAY_OUT, lrts_pkg::PH_ADD}));
    script.push_back(mk_row(lrts_pkg::MODE_TICK, 0, 0, -32'sd6258, 1'b1,
                            '{lrts_pkg::TQ_ZERO, lrts_pkg::PH_IDLE}));
    script.push_back(mk_row(lrts_pkg::MODE_ADD, HMAX, 0, 32'h7FFF_FFFF, 1'b1,
                            '{lrts_pkg::TQ_ZERO, lrts_pkg::PH_ADD}));
    // A full positive-to-negative swing of the position never pays out.
    script.push_back(mk_row(lrts_pkg::MODE_TICK, 0, 0, 32'h8000_0000, 1'b1,
                            '{lrts_pkg::TQ_ZERO, lrts_pkg::PH_IDLE}));
    script.push_back(mk_row(lrts_pkg::MODE_UP, HMAX, 0, 0, 1'b1,
                            '{lrts_pkg::TQ_ZERO, lrts_pkg::PH_UP}));
    script.push_back(mk_row(lrts_pkg::MODE_TICK, 0, 0, 0, 1'b1,
                            '{lrts_pkg::TQ_HOLD, lrts_pkg::PH_IDLE}));
    script.push_back(mk_row(lrts_pkg::MODE_ADD, 0, 0, 5, 1'b1,
                            '{lrts_pkg::TQ_ZERO, lrts_pkg::PH_ADD}));
    script.push_back(mk_row(lrts_pkg::MODE_TICK, 0, 0, 5, 1'b1,
                            '{lrts_pkg::TQ_ZERO, lrts_pkg::PH_IDLE}));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[i])
      send_req(script[i].mode, script[i].target, script[i].height, script[i].pos,
               script[i].pinned, script[i].want);
    drain();

    for (ph = 0; ph < N_SETTINGS; ph++) begin
      case (ph)
        0: program_regs(24'(lrts_pkg::LIMIT_RESET), 24'(lrts_pkg::TIMEOUT_RESET),
                        24'(lrts_pkg::GAIN_RESET));
        1: program_regs(24'd0, 24'd0, 24'd0);
        2: program_regs('1, '1, '1);
        3: program_regs(24'd600, 24'd12, 24'd65536);
        4: program_regs(24'($urandom_range(0, 1000)), 24'($urandom_range(0, 40)),
                        24'($urandom));
        default: program_regs(24'd10000, 24'(lrts_pkg::TIMEOUT_RESET),
                              24'(lrts_pkg::GAIN_RESET));
      endcase
      src_idle = (ph != N_SETTINGS - 1);
      snk_idle = (ph != N_SETTINGS - 1);
      if (ph == 2) pressure_go = 1'b1;
      goal = sent + ITEMS_PER_SETTING;
      while (sent < goal) run_motion();
      drain();
    end

    repeat (8) @(posedge clk);
    $display("Drove %0d requests over %0d register settings: %0d go-up, %0d go-down,",
             n_req, N_SETTINGS + 1, cnt_mode[lrts_pkg::MODE_UP],
             cnt_mode[lrts_pkg::MODE_DOWN]);
    $display("%0d remove-slack, %0d add-slack, %0d spare-mode; %0d results, %0d mismatches.",
             cnt_mode[lrts_pkg::MODE_REMOVE], cnt_mode[lrts_pkg::MODE_ADD],
             cnt_mode[MODE_SPARE_LO] + cnt_mode[MODE_SPARE_MID] + cnt_mode[MODE_SPARE_HI],
             n_res, bad);
    if (bad == 0 && torque_due.size() == 0) begin
      $display("lift_reset_torque_sequencer_tb: PASS");
    end else begin
      $display("lift_reset_torque_sequencer_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/lrts_pkg.sv
sv/lrts_front.sv
sv/lrts_core.sv
sv/lift_reset_torque_sequencer.sv
bench/lift_reset_torque_sequencer_tb.sv
